// ===== rtl/selective_repeat_receive_window_assert.svh =====
// ----------------------------------------------------------------------------
// Selective repeat receive window - assertion macros
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SRRW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SRRW_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define SRRW_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== rtl/srrw_pkg.sv =====
// ----------------------------------------------------------------------------
// srrw_pkg
// Types and constants of the selective repeat receive window.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package srrw_pkg;

   localparam int DefaultMaxWindow = 32;
   localparam int ResultCap        = 32;

   localparam int OffsetW = 32;
   localparam int FragW   = 11;
   localparam int WinW    = 6;
   localparam int AgeW    = 16;

   localparam int DivSteps = OffsetW;
   localparam int DivCntW  = $clog2(DivSteps);

   localparam logic [AgeW-1:0]  InitialAge    = 16'd10;
   localparam logic [AgeW-1:0]  AgeMax        = 16'hFFFF;
   localparam logic [FragW-1:0] FragSizeReset = 11'd1000;
   localparam logic [WinW-1:0]  WinSizeReset  = 6'd8;
   localparam logic [AgeW-1:0]  TimeoutReset  = 16'd100;

   typedef enum logic [1:0] {
      CSR_FILE_SIZE          = 2'd0,
      CSR_FRAGMENT_SIZE      = 2'd1,
      CSR_WINDOW_SIZE        = 2'd2,
      CSR_RETRANSMIT_TIMEOUT = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_TICK     = 1'b0,
      OP_RESPONSE = 1'b1
   } op_type;

   typedef enum logic {
      KIND_REQUEST = 1'b0,
      KIND_COMMIT  = 1'b1
   } kind_type;

   typedef struct packed {
      op_type             op;
      logic [OffsetW-1:0] resp_offset;
   } req_type;

   typedef struct packed {
      kind_type           kind;
      logic [OffsetW-1:0] frag_offset;
      logic [FragW-1:0]   frag_length;
      logic               transfer_done;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic            received;
      logic [AgeW-1:0] age;
   } slot_entry_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_NDIV,
      ST_QDIV,
      ST_RCHK,
      ST_RMARK,
      ST_CRD,
      ST_CEV,
      ST_TRD,
      ST_TEV,
      ST_MUL,
      ST_EMIT,
      ST_FLUSH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/selective_repeat_receive_window.sv =====
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// Receiver side of a selective repeat transfer: ages window slots, requests
// timed-out fragments and commits received fragments in order.
// ----------------------------------------------------------------------------
// Usage
//   req channel : one item is a tick (op = OP_TICK) or a data response
//                 (op = OP_RESPONSE, resp_offset = byte offset in its header).
//   rsp channel : zero to 32 items per req item; last marks the final one.
//                 A tick yields fragment requests, a response yields in-order
//                 commits; transfer_done rides on the commit that closes the file.
//   csr channel : register writes, only while no req item is in flight.
//                 A write of file_size or fragment_size recomputes the fragment
//                 count in the divider; req_ready stays low until it is done.
//   Sequence    : a tick walks every slot of the slot RAM. A response runs
//                 the 32-step divider for its fragment index, then marks the
//                 slot and checks the window base for each commit. Requests and
//                 commits each pass the 32x11 offset multiplier. A tick or
//                 response after the transfer is finished gives nothing.
//   Reset       : window at fragment 0, all slots unreceived with age 10, the
//                 slot RAM valid bits cleared at once (no clearing pass).
//   Stall       : one result is held back to learn whether it is the last one;
//                 when rsp_ready is low, the walk stops at the next result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "selective_repeat_receive_window_assert.svh"

module selective_repeat_receive_window
   import srrw_pkg::*;
#(
   parameter int MAX_WINDOW = DefaultMaxWindow
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_ready,
   input  wire req_type       req_payload,
   output      logic          rsp_valid,
   input  wire logic          rsp_ready,
   output      rsp_type       rsp_payload,
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire csr_index_type csr_index,
   input  wire logic [31:0]   csr_wdata
);

   localparam int SlotW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int ScanW  = $clog2(MAX_WINDOW + 1);
   localparam int WinCap = (MAX_WINDOW < ResultCap) ? MAX_WINDOW : ResultCap;
   localparam int CntW   = $clog2(ResultCap + 1);
   localparam int ProdW  = OffsetW + FragW;

   // ---------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------
   state_type          state_ff,      state_in;
   logic [OffsetW-1:0] file_size_ff,  file_size_in;
   logic [FragW-1:0]   frag_size_ff,  frag_size_in;
   logic [WinW-1:0]    win_size_ff,   win_size_in;
   logic [AgeW-1:0]    timeout_ff,    timeout_in;
   logic [OffsetW-1:0] n_ff,          n_in;          // fragment count
   logic [OffsetW-1:0] base_ff,       base_in;       // window base fragment
   logic [SlotW-1:0]   base_slot_ff,  base_slot_in;  // base mod MAX_WINDOW
   logic [AgeW-1:0]    elapsed_ff,    elapsed_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               out_valid_ff,  out_valid_in;

   logic [OffsetW-1:0] div_num_ff,    div_num_in;
   logic [FragW-1:0]   div_rem_ff,    div_rem_in;
   logic [DivCntW-1:0] div_cnt_ff,    div_cnt_in;
   logic [OffsetW-1:0] idx_ff,        idx_in;
   logic [ScanW-1:0]   scan_cnt_ff,   scan_cnt_in;
   logic [SlotW-1:0]   scan_slot_ff,  scan_slot_in;
   logic [CntW-1:0]    commit_cnt_ff, commit_cnt_in;
   logic [OffsetW-1:0] emit_idx_ff,   emit_idx_in;
   kind_type           emit_kind_ff,  emit_kind_in;
   logic               emit_done_ff,  emit_done_in;
   logic               ret_commit_ff, ret_commit_in;
   logic [ProdW-1:0]   prod_ff,       prod_in;
   rsp_type            pend_ff,       pend_in;
   rsp_type            out_ff,        out_in;

   // ---------------------------------------------------------------------
   // Slot RAM: one entry per slot, valid bits give the reset value
   // ---------------------------------------------------------------------
   slot_entry_type          slot_mem [MAX_WINDOW];
   logic [MAX_WINDOW-1:0]   slot_valid_ff;
   slot_entry_type          rd_data_ff;
   logic                    rd_valid_ff;
   slot_entry_type          rd_entry;

   logic                    mem_we;
   logic                    mem_re;
   logic [SlotW-1:0]        mem_waddr;
   logic [SlotW-1:0]        mem_raddr;
   slot_entry_type          mem_wdata;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff  <= slot_mem[mem_raddr];
         rd_valid_ff <= slot_valid_ff[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else if (mem_we) begin
         slot_valid_ff[mem_waddr] <= 1'b1;
      end
   end

   always_comb begin
      if (rd_valid_ff) begin
         rd_entry = rd_data_ff;
      end else begin
         rd_entry.received = 1'b0;
         rd_entry.age      = InitialAge;
      end
   end

   // ---------------------------------------------------------------------
   // Derived values
   // ---------------------------------------------------------------------
   logic [FragW-1:0]   f_eff;
   logic [WinW-1:0]    w_raw;
   logic [6:0]         w_eff;
   logic               xfer_active;
   logic               out_free;
   logic [AgeW:0]      fresh_sum;
   logic [AgeW-1:0]    fresh_age;
   logic [AgeW-1:0]    elapsed_inc;
   logic [SlotW-1:0]   base_slot_inc;
   logic [SlotW-1:0]   scan_slot_inc;

   assign f_eff       = (frag_size_ff == '0) ? FragW'(1) : frag_size_ff;
   assign w_raw       = (win_size_ff == '0) ? WinW'(1) : win_size_ff;
   assign w_eff       = (7'(w_raw) > 7'(WinCap)) ? 7'(WinCap) : 7'(w_raw);
   assign xfer_active = base_ff < n_ff;
   assign out_free    = !out_valid_ff || rsp_ready;
   assign fresh_sum   = (AgeW+1)'(elapsed_ff) + (AgeW+1)'(InitialAge);
   assign fresh_age   = fresh_sum[AgeW] ? AgeMax : fresh_sum[AgeW-1:0];
   assign elapsed_inc = (elapsed_ff == AgeMax) ? elapsed_ff : elapsed_ff + AgeW'(1);

   assign base_slot_inc = (base_slot_ff == SlotW'(MAX_WINDOW - 1)) ? '0
                                                                  : base_slot_ff + SlotW'(1);
   assign scan_slot_inc = (scan_slot_ff == SlotW'(MAX_WINDOW - 1)) ? '0
                                                                  : scan_slot_ff + SlotW'(1);

   // restoring divider, one quotient bit per cycle (remainder stays below f)
   logic [FragW:0]     div_shift;
   logic [FragW:0]     div_f;
   logic               div_ge;
   logic [FragW-1:0]   div_rem_next;
   logic [FragW:0]     div_diff;
   logic [OffsetW-1:0] div_q_next;

   assign div_shift    = {div_rem_ff, div_num_ff[OffsetW-1]};
   assign div_f        = {1'b0, f_eff};
   assign div_ge       = div_shift >= div_f;
   assign div_diff     = div_shift - div_f;
   assign div_rem_next = div_ge ? div_diff[FragW-1:0] : div_shift[FragW-1:0];
   assign div_q_next   = {div_num_ff[OffsetW-2:0], div_ge};

   // response window check and slot of the fragment
   logic [OffsetW:0]   win_end;
   logic               resp_in_window;
   logic [OffsetW-1:0] resp_off;
   logic [SlotW:0]     resp_sum;
   logic [SlotW-1:0]   resp_slot;

   assign win_end        = {1'b0, base_ff} + (OffsetW+1)'(w_eff);
   assign resp_in_window = (idx_ff >= base_ff) && ({1'b0, idx_ff} < win_end)
                           && (idx_ff < n_ff);
   assign resp_off       = idx_ff - base_ff;
   assign resp_sum       = (SlotW+1)'(base_slot_ff) + resp_off[SlotW:0];
   assign resp_slot      = (resp_sum >= (SlotW+1)'(MAX_WINDOW))
                           ? SlotW'(resp_sum - (SlotW+1)'(MAX_WINDOW))
                           : resp_sum[SlotW-1:0];

   // tick scan: aged value and request decision for the slot just read
   logic [OffsetW:0]   scan_idx;
   logic [AgeW-1:0]    age_next;
   logic               scan_hit;
   logic               scan_last;

   assign scan_idx  = {1'b0, base_ff} + (OffsetW+1)'(scan_cnt_ff);
   assign age_next  = (rd_entry.age == AgeMax) ? AgeMax : rd_entry.age + AgeW'(1);
   assign scan_hit  = (7'(scan_cnt_ff) < w_eff) && (scan_idx < {1'b0, n_ff})
                      && !rd_entry.received && (age_next >= timeout_ff);
   assign scan_last = scan_cnt_ff == ScanW'(MAX_WINDOW - 1);

   // result build from the registered product
   logic               start_in_file;
   logic [OffsetW-1:0] remain;
   rsp_type            new_rsp;

   assign start_in_file = prod_ff < ProdW'(file_size_ff);
   assign remain        = file_size_ff - prod_ff[OffsetW-1:0];

   always_comb begin
      new_rsp.kind          = emit_kind_ff;
      new_rsp.frag_offset   = prod_ff[OffsetW-1:0];
      new_rsp.transfer_done = emit_done_ff;
      new_rsp.last          = 1'b0;
      if (!start_in_file) begin
         new_rsp.frag_length = '0;
      end else if (remain > OffsetW'(f_eff)) begin
         new_rsp.frag_length = f_eff;
      end else begin
         new_rsp.frag_length = remain[FragW-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign req_ready   = (state_ff == ST_IDLE) && !csr_valid;
   assign csr_ready   = state_ff == ST_IDLE;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   always_comb begin
      state_in      = state_ff;
      file_size_in  = file_size_ff;
      frag_size_in  = frag_size_ff;
      win_size_in   = win_size_ff;
      timeout_in    = timeout_ff;
      n_in          = n_ff;
      base_in       = base_ff;
      base_slot_in  = base_slot_ff;
      elapsed_in    = elapsed_ff;
      pend_valid_in = pend_valid_ff;
      out_valid_in  = out_valid_ff;
      div_num_in    = div_num_ff;
      div_rem_in    = div_rem_ff;
      div_cnt_in    = div_cnt_ff;
      idx_in        = idx_ff;
      scan_cnt_in   = scan_cnt_ff;
      scan_slot_in  = scan_slot_ff;
      commit_cnt_in = commit_cnt_ff;
      emit_idx_in   = emit_idx_ff;
      emit_kind_in  = emit_kind_ff;
      emit_done_in  = emit_done_ff;
      ret_commit_in = ret_commit_ff;
      prod_in       = prod_ff;
      pend_in       = pend_ff;
      out_in        = out_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = scan_slot_ff;
      mem_raddr     = scan_slot_ff;
      mem_wdata     = rd_entry;

      if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  CSR_FILE_SIZE: begin
                     file_size_in = csr_wdata;
                     div_num_in   = csr_wdata;
                     div_rem_in   = '0;
                     div_cnt_in   = '0;
                     state_in     = ST_NDIV;
                  end
                  CSR_FRAGMENT_SIZE: begin
                     frag_size_in = csr_wdata[FragW-1:0];
                     div_num_in   = file_size_ff;
                     div_rem_in   = '0;
                     div_cnt_in   = '0;
                     state_in     = ST_NDIV;
                  end
                  CSR_WINDOW_SIZE: begin
                     win_size_in = csr_wdata[WinW-1:0];
                  end
                  CSR_RETRANSMIT_TIMEOUT: begin
                     timeout_in = csr_wdata[AgeW-1:0];
                  end
                  default: begin
                  end
               endcase
            end else if (req_valid) begin
               if (req_payload.op == OP_TICK) begin
                  elapsed_in = elapsed_inc;
                  if (xfer_active) begin
                     scan_cnt_in  = '0;
                     scan_slot_in = base_slot_ff;
                     state_in     = ST_TRD;
                  end
               end else if (xfer_active) begin
                  div_num_in = req_payload.resp_offset;
                  div_rem_in = '0;
                  div_cnt_in = '0;
                  state_in   = ST_QDIV;
               end
            end
         end

         ST_NDIV, ST_QDIV: begin
            div_num_in = div_q_next;
            div_rem_in = div_rem_next;
            div_cnt_in = div_cnt_ff + DivCntW'(1);
            if (div_cnt_ff == DivCntW'(DivSteps - 1)) begin
               if (state_ff == ST_NDIV) begin
                  // ceiling: one more fragment for a short tail
                  n_in     = div_q_next + OffsetW'(div_rem_next != '0);
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = div_q_next;
                  state_in = ST_RCHK;
               end
            end
         end

         ST_RCHK: begin
            if (resp_in_window) begin
               scan_slot_in = resp_slot;
               mem_re       = 1'b1;
               mem_raddr    = resp_slot;
               state_in     = ST_RMARK;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_RMARK: begin
            if (rd_entry.received) begin
               // duplicate response
               state_in = ST_IDLE;
            end else begin
               mem_we             = 1'b1;
               mem_waddr          = scan_slot_ff;
               mem_wdata.received = 1'b1;
               mem_wdata.age      = rd_entry.age;
               commit_cnt_in      = '0;
               state_in           = ST_CRD;
            end
         end

         ST_CRD: begin
            if (xfer_active && (commit_cnt_ff < CntW'(ResultCap))) begin
               mem_re    = 1'b1;
               mem_raddr = base_slot_ff;
               state_in  = ST_CEV;
            end else begin
               state_in = ST_FLUSH;
            end
         end

         ST_CEV: begin
            if (rd_entry.received) begin
               // slot goes to the fragment MAX_WINDOW further on
               mem_we             = 1'b1;
               mem_waddr          = base_slot_ff;
               mem_wdata.received = 1'b0;
               mem_wdata.age      = fresh_age;
               emit_idx_in        = base_ff;
               emit_kind_in       = KIND_COMMIT;
               emit_done_in       = ({1'b0, base_ff} + (OffsetW+1)'(1)) >= {1'b0, n_ff};
               base_in            = base_ff + OffsetW'(1);
               base_slot_in       = base_slot_inc;
               commit_cnt_in      = commit_cnt_ff + CntW'(1);
               ret_commit_in      = 1'b1;
               state_in           = ST_MUL;
            end else begin
               state_in = ST_FLUSH;
            end
         end

         ST_TRD: begin
            mem_re    = 1'b1;
            mem_raddr = scan_slot_ff;
            state_in  = ST_TEV;
         end

         ST_TEV: begin
            mem_we             = 1'b1;
            mem_waddr          = scan_slot_ff;
            mem_wdata.received = rd_entry.received;
            mem_wdata.age      = scan_hit ? '0 : age_next;
            if (scan_hit) begin
               emit_idx_in   = scan_idx[OffsetW-1:0];
               emit_kind_in  = KIND_REQUEST;
               emit_done_in  = 1'b0;
               ret_commit_in = 1'b0;
               scan_cnt_in   = scan_cnt_ff + ScanW'(1);
               scan_slot_in  = scan_slot_inc;
               state_in      = ST_MUL;
            end else if (scan_last) begin
               state_in = ST_FLUSH;
            end else begin
               // read the next slot while this one is written back
               scan_cnt_in  = scan_cnt_ff + ScanW'(1);
               scan_slot_in = scan_slot_inc;
               mem_re       = 1'b1;
               mem_raddr    = scan_slot_inc;
            end
         end

         ST_MUL: begin
            prod_in  = ProdW'(emit_idx_ff) * ProdW'(f_eff);
            state_in = ST_EMIT;
         end

         ST_EMIT: begin
            if (!pend_valid_ff || out_free) begin
               if (pend_valid_ff) begin
                  out_in       = pend_ff;
                  out_valid_in = 1'b1;
               end
               pend_in       = new_rsp;
               pend_valid_in = 1'b1;
               if (ret_commit_ff) begin
                  state_in = ST_CRD;
               end else if (scan_cnt_ff == ScanW'(MAX_WINDOW)) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_TRD;
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in        = pend_ff;
               out_in.last   = 1'b1;
               out_valid_in  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         file_size_ff  <= '0;
         frag_size_ff  <= FragSizeReset;
         win_size_ff   <= WinSizeReset;
         timeout_ff    <= TimeoutReset;
         n_ff          <= '0;
         base_ff       <= '0;
         base_slot_ff  <= '0;
         elapsed_ff    <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         file_size_ff  <= file_size_in;
         frag_size_ff  <= frag_size_in;
         win_size_ff   <= win_size_in;
         timeout_ff    <= timeout_in;
         n_ff          <= n_in;
         base_ff       <= base_in;
         base_slot_ff  <= base_slot_in;
         elapsed_ff    <= elapsed_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_num_ff    <= div_num_in;
      div_rem_ff    <= div_rem_in;
      div_cnt_ff    <= div_cnt_in;
      idx_ff        <= idx_in;
      scan_cnt_ff   <= scan_cnt_in;
      scan_slot_ff  <= scan_slot_in;
      commit_cnt_ff <= commit_cnt_in;
      emit_idx_ff   <= emit_idx_in;
      emit_kind_ff  <= emit_kind_in;
      emit_done_ff  <= emit_done_in;
      ret_commit_ff <= ret_commit_in;
      prod_ff       <= prod_in;
      pend_ff       <= pend_in;
      out_ff        <= out_in;
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   `SRRW_ASSERT_IMPLY(a_idle_no_pending, clock, reset, state_ff == ST_IDLE,
      !pend_valid_ff, "held-back result left behind in idle")
   `SRRW_ASSERT_IMPLY(a_done_is_last, clock, reset,
      rsp_valid && (rsp_payload.kind == KIND_COMMIT) && rsp_payload.transfer_done,
      rsp_payload.last, "closing commit not marked last")
   `SRRW_ASSERT_IMPLY(a_request_not_done, clock, reset,
      rsp_valid && (rsp_payload.kind == KIND_REQUEST),
      !rsp_payload.transfer_done, "request carries done flag")
   `SRRW_ASSERT_IMPLY(a_commit_cap, clock, reset, state_ff == ST_CEV,
      commit_cnt_ff < CntW'(ResultCap), "commit run past cap")
   `SRRW_ASSERT_NEXT(a_size_write_recount, clock, reset,
      csr_valid && csr_ready && (csr_index == CSR_FILE_SIZE),
      state_ff == ST_NDIV, "file size write did not start recount")

endmodule

`default_nettype wire
